>>> sv/tbc_pkg.sv
package tbc_pkg;

   localparam int MAX_TILES = 16;
   localparam int MASK_W    = 16;
   localparam int NUM_CELLS = (MAX_TILES < MASK_W) ? MAX_TILES : MASK_W;
   localparam int INDEX_W   = 4;
   localparam int COUNT_W   = 5;
   localparam int LON_W     = 32;
   localparam int LAT_W     = 31;
   localparam int COORD_W   = 32;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_POINT = 2'd1,
      OP_NODE  = 2'd2,
      OP_NONE  = 2'd3
   } tbc_op_type;

   typedef struct packed {
      logic                       valid;
      logic                       is_load;
      logic                       emit;
      logic                       is_way;
      logic                       empty;
      logic [INDEX_W-1:0]         index;
      logic signed [COORD_W-1:0]  min_lon;
      logic signed [COORD_W-1:0]  max_lon;
      logic signed [COORD_W-1:0]  min_lat;
      logic signed [COORD_W-1:0]  max_lat;
      logic [MASK_W-1:0]          mask;
   } tbc_beat_type;

endpackage

>>> sv/tbc_front.sv
module tbc_front import tbc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      advance,
   input  logic [1:0]                op,
   input  logic signed [LON_W-1:0]   lon,
   input  logic signed [LAT_W-1:0]   lat,
   input  logic signed [LON_W-1:0]   lon_second,
   input  logic signed [LAT_W-1:0]   lat_second,
   input  logic [INDEX_W-1:0]        tile_index,
   input  logic                      location_valid,
   input  logic                      last_node,
   output tbc_beat_type              beat_out
);

   logic signed [COORD_W-1:0] way_min_lon_ff, way_min_lon_in;
   logic signed [COORD_W-1:0] way_max_lon_ff, way_max_lon_in;
   logic signed [COORD_W-1:0] way_min_lat_ff, way_min_lat_in;
   logic signed [COORD_W-1:0] way_max_lat_ff, way_max_lat_in;
   logic                      way_box_valid_ff, way_box_valid_in;
   tbc_beat_type              beat_ff, beat_in;

   logic signed [COORD_W-1:0] lon_x, lat_x, lon2_x, lat2_x;
   logic signed [COORD_W-1:0] grow_min_lon, grow_max_lon, grow_min_lat, grow_max_lat;

   assign lon_x  = COORD_W'(lon);
   assign lat_x  = COORD_W'(lat);
   assign lon2_x = COORD_W'(lon_second);
   assign lat2_x = COORD_W'(lat_second);

   // running box grown by the current node
   always_comb begin
      if (!way_box_valid_ff) begin
         grow_min_lon = lon_x;
         grow_max_lon = lon_x;
         grow_min_lat = lat_x;
         grow_max_lat = lat_x;
      end else begin
         grow_min_lon = (lon_x < way_min_lon_ff) ? lon_x : way_min_lon_ff;
         grow_max_lon = (lon_x > way_max_lon_ff) ? lon_x : way_max_lon_ff;
         grow_min_lat = (lat_x < way_min_lat_ff) ? lat_x : way_min_lat_ff;
         grow_max_lat = (lat_x > way_max_lat_ff) ? lat_x : way_max_lat_ff;
      end
   end

   always_comb begin
      way_min_lon_in   = way_min_lon_ff;
      way_max_lon_in   = way_max_lon_ff;
      way_min_lat_in   = way_min_lat_ff;
      way_max_lat_in   = way_max_lat_ff;
      way_box_valid_in = way_box_valid_ff;

      beat_in         = '0;
      beat_in.valid   = accept;
      beat_in.index   = tile_index;
      beat_in.min_lon = lon_x;
      beat_in.max_lon = lon_x;
      beat_in.min_lat = lat_x;
      beat_in.max_lat = lat_x;

      case (tbc_op_type'(op))
         OP_LOAD: begin
            beat_in.is_load = 1'b1;
            beat_in.min_lon = (lon_x < lon2_x) ? lon_x : lon2_x;
            beat_in.max_lon = (lon_x < lon2_x) ? lon2_x : lon_x;
            beat_in.min_lat = (lat_x < lat2_x) ? lat_x : lat2_x;
            beat_in.max_lat = (lat_x < lat2_x) ? lat2_x : lat_x;
         end
         OP_POINT: begin
            beat_in.emit = 1'b1;
         end
         OP_NODE: begin
            if (location_valid) begin
               way_min_lon_in   = grow_min_lon;
               way_max_lon_in   = grow_max_lon;
               way_min_lat_in   = grow_min_lat;
               way_max_lat_in   = grow_max_lat;
               way_box_valid_in = 1'b1;
            end
            beat_in.emit    = last_node;
            beat_in.is_way  = 1'b1;
            beat_in.empty   = !way_box_valid_in;
            beat_in.min_lon = way_min_lon_in;
            beat_in.max_lon = way_max_lon_in;
            beat_in.min_lat = way_min_lat_in;
            beat_in.max_lat = way_max_lat_in;
            if (last_node) begin
               way_min_lon_in   = '0;
               way_max_lon_in   = '0;
               way_min_lat_in   = '0;
               way_max_lat_in   = '0;
               way_box_valid_in = 1'b0;
            end
         end
         default: begin
            beat_in.emit = 1'b0;
         end
      endcase

      if (!accept) begin
         way_min_lon_in   = way_min_lon_ff;
         way_max_lon_in   = way_max_lon_ff;
         way_min_lat_in   = way_min_lat_ff;
         way_max_lat_in   = way_max_lat_ff;
         way_box_valid_in = way_box_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         way_min_lon_ff   <= '0;
         way_max_lon_ff   <= '0;
         way_min_lat_ff   <= '0;
         way_max_lat_ff   <= '0;
         way_box_valid_ff <= 1'b0;
         beat_ff.valid    <= 1'b0;
      end else begin
         way_min_lon_ff   <= way_min_lon_in;
         way_max_lon_ff   <= way_max_lon_in;
         way_min_lat_ff   <= way_min_lat_in;
         way_max_lat_ff   <= way_max_lat_in;
         way_box_valid_ff <= way_box_valid_in;
         if (advance) begin
            beat_ff <= beat_in;
         end
      end
   end

   assign beat_out = beat_ff;

endmodule

>>> sv/tbc_cell.sv
module tbc_cell import tbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [INDEX_W-1:0] cell_id,
   input  logic               active,
   input  tbc_beat_type       beat_in,
   output tbc_beat_type       beat_out
);

   logic signed [COORD_W-1:0] tile_min_lon_ff, tile_max_lon_ff;
   logic signed [COORD_W-1:0] tile_min_lat_ff, tile_max_lat_ff;
   tbc_beat_type              beat_ff, beat_next;
   logic                      hit;
   logic                      load_here;

   // strict overlap; a point arrives as a zero-size box
   assign hit = beat_in.valid && !beat_in.is_load && !beat_in.empty && active &&
                (beat_in.max_lon > tile_min_lon_ff) && (beat_in.min_lon < tile_max_lon_ff) &&
                (beat_in.max_lat > tile_min_lat_ff) && (beat_in.min_lat < tile_max_lat_ff);

   assign load_here = advance && beat_in.valid && beat_in.is_load &&
                      (beat_in.index == cell_id);

   always_comb begin
      beat_next = beat_in;
      beat_next.mask[cell_id] = beat_in.mask[cell_id] | hit;
   end

   always_ff @(posedge clock) begin
      if (load_here) begin
         tile_min_lon_ff <= beat_in.min_lon;
         tile_max_lon_ff <= beat_in.max_lon;
         tile_min_lat_ff <= beat_in.min_lat;
         tile_max_lat_ff <= beat_in.max_lat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_next;
      end
   end

   assign beat_out = beat_ff;

endmodule

>>> sv/tile_box_classifier_core.sv
// channel  | dir | handshake           | payload
// req      | in  | req_valid/req_ready | op, lon, lat, corners, tile_index, flags
// rsp      | out | rsp_valid/rsp_ready | tile_mask, is_way
// csr      | in  | csr_wr_en           | tile_count
//
// one beat per cycle unless the chain holds; a result is offered after its beat is
// registered in the front stage when taken, then in one cell per tile
// the chain moves as a whole; it holds only while a result waits on rsp_ready
// loads and non-final nodes travel the chain but give no result
// synchronous reset clears valids, the way box and tile_count; tiles need a load
module tile_box_classifier_core import tbc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_op,
   input  logic signed [LON_W-1:0]  req_lon,
   input  logic signed [LAT_W-1:0]  req_lat,
   input  logic signed [LON_W-1:0]  req_lon_second,
   input  logic signed [LAT_W-1:0]  req_lat_second,
   input  logic [INDEX_W-1:0]       req_tile_index,
   input  logic                     req_location_valid,
   input  logic                     req_last_node,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [MASK_W-1:0]        rsp_tile_mask,
   output logic                     rsp_is_way,
   input  logic                     csr_wr_en,
   input  logic [COUNT_W-1:0]       csr_wr_data
);

   logic [COUNT_W-1:0] tile_count_ff;
   logic               advance;
   logic               accept;
   tbc_beat_type       chain [NUM_CELLS+1];
   tbc_beat_type       tail;

   assign tail      = chain[NUM_CELLS];
   assign advance   = !(tail.valid && tail.emit) || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_count_ff <= '0;
      end else if (csr_wr_en) begin
         tile_count_ff <= csr_wr_data;
      end
   end

   tbc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .advance        (advance),
      .op             (req_op),
      .lon            (req_lon),
      .lat            (req_lat),
      .lon_second     (req_lon_second),
      .lat_second     (req_lat_second),
      .tile_index     (req_tile_index),
      .location_valid (req_location_valid),
      .last_node      (req_last_node),
      .beat_out       (chain[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      tbc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_id  (INDEX_W'(i)),
         .active   (tile_count_ff > COUNT_W'(i)),
         .beat_in  (chain[i]),
         .beat_out (chain[i+1])
      );
   end

   assign rsp_valid     = tail.valid && tail.emit;
   assign rsp_tile_mask = tail.mask;
   assign rsp_is_way    = tail.is_way;

endmodule
